// ===== design/sud_pkg.sv =====
// shared types and constants for the signed/unsigned divider
// no dependencies; imported by every module of the block
package sud_pkg;

  // fixed field widths of the ports
  localparam int unsigned OPND_W = 32;
  localparam int unsigned QUOT_W = 32;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // action codes
  localparam logic ACT_UNSIGNED = 1'b0;
  localparam logic ACT_SIGNED   = 1'b1;

  // classification flags formed by the front part
  typedef struct packed {
    logic flip;   // operand signs differ, negate the quotient
    logic zero;   // divisor is zero, force the quotient to zero
  } sud_flags_t;

endpackage

// ===== design/sud_front.sv =====
// front part: accepts input beats, takes operand magnitudes and flags
// depends on sud_pkg; feeds sud_queue
module sud_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [sud_pkg::OPND_W-1:0]    in_dividend,
  input  logic [sud_pkg::OPND_W-1:0]    in_divisor,
  output logic                          f_valid,
  input  logic                          f_full,
  output logic [DATA_WIDTH-1:0]         f_num,
  output logic [DATA_WIDTH-1:0]         f_den,
  output sud_pkg::sud_flags_t           f_flags
);
  import sud_pkg::*;

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] num_r;
  logic [DATA_WIDTH-1:0] den_r;
  sud_flags_t            flags_r;

  logic [DATA_WIDTH-1:0] num_w;
  logic [DATA_WIDTH-1:0] den_w;
  logic                  num_neg;
  logic                  den_neg;
  logic                  accept;

  // operands taken modulo 2^DATA_WIDTH
  assign num_w   = DATA_WIDTH'(in_dividend);
  assign den_w   = DATA_WIDTH'(in_divisor);
  assign num_neg = (in_action == ACT_SIGNED) && num_w[DATA_WIDTH-1];
  assign den_neg = (in_action == ACT_SIGNED) && den_w[DATA_WIDTH-1];

  assign in_stall = valid_r && f_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num_r        <= num_neg ? (~num_w + 1'b1) : num_w;
      den_r        <= den_neg ? (~den_w + 1'b1) : den_w;
      flags_r.flip <= num_neg ^ den_neg;
      flags_r.zero <= (den_w == '0);
    end
  end

  assign f_valid = valid_r;
  assign f_num   = num_r;
  assign f_den   = den_r;
  assign f_flags = flags_r;

endmodule

// ===== design/sud_queue.sv =====
// short fifo between the front and back parts
// depends on sud_pkg for depth and pointer widths
module sud_queue #(
  parameter int unsigned DATA_W = 66
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output logic [DATA_W-1:0] q_data
);
  import sud_pkg::*;

  logic [DATA_W-1:0] mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== design/sud_back.sv =====
// back part: restoring divide pipeline, one quotient bit per stage,
// then sign fixup and output register; depends on sud_pkg
module sud_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [DATA_WIDTH-1:0]      q_num,
  input  logic [DATA_WIDTH-1:0]      q_den,
  input  sud_pkg::sud_flags_t        q_flags,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sud_pkg::QUOT_W-1:0] out_quotient
);
  import sud_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic [W:0]   valid_r;
  logic [W-1:0] rem_r   [0:W];
  logic [W-1:0] nq_r    [0:W];
  logic [W-1:0] den_r   [0:W];
  sud_flags_t   flags_r [0:W];

  logic [W-1:0] rem_nxt [0:W-1];
  logic [W-1:0] nq_nxt  [0:W-1];

  logic              out_valid_r;
  logic [QUOT_W-1:0] out_quotient_r;
  logic [W-1:0]      quo_fix;
  logic              advance;

  // whole pipeline moves unless a finished beat is held at the output
  assign advance = !(out_valid_r && out_stall);
  assign q_pop   = advance && q_valid;

  // one restoring step per stage; nq shifts out dividend bits, in quotient bits
  always_comb begin
    logic [W:0]   shifted;
    logic [W+1:0] diff;
    for (int k = 0; k < W; k++) begin
      shifted    = {rem_r[k], nq_r[k][W-1]};
      diff       = {1'b0, shifted} - {2'b00, den_r[k]};
      rem_nxt[k] = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      nq_nxt[k]  = {nq_r[k][W-2:0], !diff[W+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      valid_r     <= {valid_r[W-1:0], q_valid};
      out_valid_r <= valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_r[0]   <= '0;
      nq_r[0]    <= q_num;
      den_r[0]   <= q_den;
      flags_r[0] <= q_flags;
      for (int k = 0; k < W; k++) begin
        rem_r[k+1]   <= rem_nxt[k];
        nq_r[k+1]    <= nq_nxt[k];
        den_r[k+1]   <= den_r[k];
        flags_r[k+1] <= flags_r[k];
      end
    end
  end

  always_comb begin
    if (flags_r[W].zero) begin
      quo_fix = '0;
    end else if (flags_r[W].flip) begin
      quo_fix = ~nq_r[W] + 1'b1;
    end else begin
      quo_fix = nq_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_r[W]) begin
      out_quotient_r <= QUOT_W'(quo_fix);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_quotient = out_quotient_r;

endmodule

// ===== design/signed_unsigned_divider_core.sv =====
// signed/unsigned 32-bit divider, top level
//
// input channel: in_valid/in_stall with in_action (0 unsigned, 1 signed),
// in_dividend and in_divisor. result channel: out_valid/out_stall with
// out_quotient. a beat moves on a rising edge with valid high, stall low.
// signed divide truncates toward zero; a zero divisor gives quotient 0;
// the most negative value over minus one wraps to the most negative value.
// a front stage takes operand magnitudes and sign flags, a four-entry queue
// decouples it from a back pipeline of DATA_WIDTH restoring stages.
// while out_stall is low, one beat per cycle is sustained through the
// front register, queue and pipeline, one pipeline stage per quotient bit.
// when out_stall holds a result, the back pipeline freezes, the queue fills,
// and in_stall rises once the queue and the front stage are both full.
// reset (rst_n low, synchronous) empties the front, queue and pipeline;
// in_stall is low and out_valid is low in the cycle after reset.
// DATA_WIDTH (8 to 64) is the datapath width: operands are taken modulo
// 2^DATA_WIDTH and the quotient is fitted to the 32-bit output.
module signed_unsigned_divider_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [sud_pkg::OPND_W-1:0] in_dividend,
  input  logic [sud_pkg::OPND_W-1:0] in_divisor,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sud_pkg::QUOT_W-1:0] out_quotient
);
  import sud_pkg::*;

  localparam int unsigned FLAGS_W = $bits(sud_flags_t);
  localparam int unsigned QDATA_W = FLAGS_W + 2 * DATA_WIDTH;

  logic                  f_valid;
  logic                  f_full;
  logic [DATA_WIDTH-1:0] f_num;
  logic [DATA_WIDTH-1:0] f_den;
  sud_flags_t            f_flags;

  logic                  q_valid;
  logic                  q_pop;
  logic [QDATA_W-1:0]    q_data;
  logic [DATA_WIDTH-1:0] q_num;
  logic [DATA_WIDTH-1:0] q_den;
  sud_flags_t            q_flags;

  sud_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .f_valid     (f_valid),
    .f_full      (f_full),
    .f_num       (f_num),
    .f_den       (f_den),
    .f_flags     (f_flags)
  );

  sud_queue #(
    .DATA_W (QDATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_flags, f_num, f_den}),
    .full      (f_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  assign {q_flags, q_num, q_den} = q_data;

  sud_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_num        (q_num),
    .q_den        (q_den),
    .q_flags      (q_flags),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_quotient (out_quotient)
  );

endmodule

// ===== design/sud_checker.sv =====
// port-level checks for the divider top level, bound to every instance
// depends on sud_pkg for the result width
module sud_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sud_pkg::QUOT_W-1:0] out_quotient
);
  import sud_pkg::*;

  // nothing may come out right after reset
  a_no_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // front and queue are empty after reset, so input is open
  a_open_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall)
    else $error("input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_quotient))
    else $error("stalled quotient changed");

endmodule

bind signed_unsigned_divider_core sud_checker u_sud_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_quotient (out_quotient)
);

// ===== verif/tb_signed_unsigned_divider_core.sv =====
// self-checking testbench for signed_unsigned_divider_core
// depends on design/sud_pkg.sv and design/signed_unsigned_divider_core.sv
// directed corner table, held-receiver burst, random beats with random stalls on both sides
`timescale 1ns / 1ps

module tb_signed_unsigned_divider_core;

  localparam int unsigned DW       = 32;
  localparam int unsigned LATENCY  = DW + 3;
  localparam int unsigned DIR_N    = 22;
  localparam int unsigned RND_N    = 1500;
  localparam int unsigned PHASE_N  = 200;
  localparam int unsigned PRESS_N  = 80;
  localparam int unsigned HOLD_CYC = 300;

  typedef struct {
    logic        act;
    logic [31:0] num;
    logic [31:0] den;
    bit          pinned;
    logic [31:0] quot;
  } div_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [31:0] in_dividend;
  logic [31:0] in_divisor;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_quotient;

  // typed expectation riding along with the current input beat
  bit          pin_on;
  logic [31:0] pin_quot;

  bit          tx_burst;
  bit          rx_burst;
  bit          rx_hold_req;

  logic [31:0] quot_fifo [$];
  int unsigned err_cnt;
  int unsigned beats_in;
  int unsigned signed_beats;
  int unsigned zero_div_beats;
  int unsigned quot_checked;
  bit          in_stall_seen;

  div_row_t corner_tab [DIR_N] = '{
    '{sud_pkg::ACT_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{sud_pkg::ACT_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
    '{sud_pkg::ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{sud_pkg::ACT_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{sud_pkg::ACT_SIGNED,   32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001},
    '{sud_pkg::ACT_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFD},
    '{sud_pkg::ACT_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD},
    '{sud_pkg::ACT_UNSIGNED, 32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'h7FFF_FFFC},
    '{sud_pkg::ACT_SIGNED,   32'h8000_0000, 32'h0000_0002, 1'b1, 32'hC000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001},
    '{sud_pkg::ACT_UNSIGNED, 32'h1234_5678, 32'h0000_1000, 1'b0, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{sud_pkg::ACT_UNSIGNED, 32'h0000_0064, 32'h0000_0007, 1'b1, 32'h0000_000E},
    '{sud_pkg::ACT_SIGNED,   32'hDEAD_BEEF, 32'h0000_1234, 1'b0, 32'h0000_0000},
    '{sud_pkg::ACT_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  signed_unsigned_divider_core #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_quotient(out_quotient)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // restoring divide on magnitudes, sign fixed up afterwards
  function automatic logic [31:0] quotient_of(input logic act, input logic [31:0] num,
                                              input logic [31:0] den);
    logic [DW-1:0] mag_n;
    logic [DW-1:0] mag_d;
    logic [DW-1:0] q;
    logic [DW:0]   part;
    logic          neg;
    mag_n = num;
    mag_d = den;
    q     = '0;
    part  = '0;
    neg   = 1'b0;
    if (act == sud_pkg::ACT_SIGNED) begin
      if (mag_n[DW-1]) begin
        mag_n = -mag_n;
        neg   = ~neg;
      end
      if (mag_d[DW-1]) begin
        mag_d = -mag_d;
        neg   = ~neg;
      end
    end
    if (mag_d == '0) return '0;
    for (int b = DW - 1; b >= 0; b--) begin
      part = {part[DW-1:0], mag_n[b]};
      if (part >= {1'b0, mag_d}) begin
        part = part - {1'b0, mag_d};
        q[b] = 1'b1;
      end
    end
    if (neg) q = -q;
    return q;
  endfunction

  // corner-heavy operand mix
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h1 << $urandom_range(0, 31);
      6:       return $urandom_range(0, 255);
      7:       return -$urandom_range(1, 255);
      8:       return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // scoreboard: record accepted input beats, check result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_stall) in_stall_seen <= 1'b1;
      if (in_valid && !in_stall) begin
        quot_fifo.push_back(pin_on ? pin_quot
                                   : quotient_of(in_action, in_dividend, in_divisor));
        beats_in++;
        if (in_action == sud_pkg::ACT_SIGNED) signed_beats++;
        if (in_divisor == '0) zero_div_beats++;
      end
      if (out_valid && !out_stall) begin
        if (quot_fifo.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("ERROR: unexpected result beat, quotient %h", out_quotient);
        end else begin
          logic [31:0] exp_q;
          exp_q = quot_fifo.pop_front();
          quot_checked++;
          if (out_quotient !== exp_q) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ERROR: quotient mismatch, expected %h actual %h", exp_q, out_quotient);
          end
        end
      end
    end
  end

  // receiver: random stall before each result, optional long hold-off
  initial begin : result_sink
    int unsigned gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (rx_hold_req) gap = HOLD_CYC;
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(input logic act, input logic [31:0] num, input logic [31:0] den,
                           input bit pinned, input logic [31:0] quot);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action   = act;
    in_dividend = num;
    in_divisor  = den;
    pin_on      = pinned;
    pin_quot    = quot;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (quot_fifo.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = sud_pkg::ACT_UNSIGNED;
    in_dividend = '0;
    in_divisor  = '0;
    pin_on      = 1'b0;
    pin_quot    = '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    rx_hold_req = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_tab[i])
      send_beat(corner_tab[i].act, corner_tab[i].num, corner_tab[i].den,
                corner_tab[i].pinned, corner_tab[i].quot);
    wait_drained();

    // back-to-back beats against a long receiver hold, fills the queue and stalls the input
    tx_burst    = 1'b1;
    rx_hold_req = 1'b1;
    repeat (PRESS_N)
      send_beat(1'($urandom_range(0, 1)), pick_operand(), pick_operand(), 1'b0, '0);
    tx_burst = 1'b0;
    wait_drained();

    for (int unsigned n = 0; n < RND_N; n++) begin
      if (n % PHASE_N == 0) begin
        tx_burst = 1'((n / PHASE_N) % 2);
        rx_burst = 1'(((n / PHASE_N) / 2) % 2);
        if (n / PHASE_N == 3) wait_drained();
      end
      send_beat(1'($urandom_range(0, 1)), pick_operand(), pick_operand(), 1'b0, '0);
    end
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);

    if (quot_fifo.size() != 0) err_cnt++;
    $display("covered %0d division beats (%0d signed, %0d with zero divisor), %0d results checked",
             beats_in, signed_beats, zero_div_beats, quot_checked);
    $display("input stall observed: %0d, failures: %0d", in_stall_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", quot_fifo.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
